>>> rtl/dclp_pkg.sv
// ----------------------------------------------------------------------------
// dclp_pkg: shared types for the duty command line parser
// Response codes and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dclp_pkg;

  // Response codes carried in the result transaction.
  typedef enum logic [2:0] {
    RESP_SET_OK   = 3'd0,
    RESP_REPORT   = 3'd1,
    RESP_UNKNOWN  = 3'd2,
    RESP_RANGE    = 3'd3,
    RESP_BAD_NUM  = 3'd4,
    RESP_MISSING  = 3'd5,
    RESP_TOO_LONG = 3'd6
  } resp_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;        // write the received byte and advance the count
    logic start_scan;   // latch the line length, clear the count, reset the parser
    logic too_long;     // flag a too-long line and clear the count
    logic set_discard;  // start dropping the rest of a too-long line
    logic clr_discard;  // a terminator ends the dropped line
    logic scan_rd;      // read the next stored byte into the parser
    logic load_out;     // load the result into the output register
  } dclp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_term;      // received byte is CR or LF
    logic cnt_zero;     // no byte stored in the current line
    logic cnt_full;     // line holds capacity minus one bytes
    logic discard;      // rest of a too-long line is being dropped
    logic scan_last;    // the read being issued is the last byte of the line
    logic has_result;   // the finished line produces a result
  } dclp_stat_t;

endpackage

>>> rtl/dclp_ctrl.sv
// ----------------------------------------------------------------------------
// dclp_ctrl: controller of the duty command line parser
// Sequences byte storage, the scan over a stored line and result delivery.
// ----------------------------------------------------------------------------
module dclp_ctrl
  import dclp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dclp_stat_t stat,
  output dclp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_accept;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_accept = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (stat.discard) begin
            cmd.clr_discard = stat.is_term;
          end else if (stat.is_term) begin
            if (stat.cnt_full) begin
              cmd.too_long = 1'b1;
              state_nxt    = ST_FINISH;
            end else if (!stat.cnt_zero) begin
              cmd.start_scan = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end else if (stat.cnt_full) begin
            cmd.too_long    = 1'b1;
            cmd.set_discard = 1'b1;
            state_nxt       = ST_FINISH;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.has_result) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/dclp_dp.sv
// ----------------------------------------------------------------------------
// dclp_dp: datapath of the duty command line parser
// Line store, byte count, a one-byte-per-cycle parser over the stored line
// and the result register.
// ----------------------------------------------------------------------------
module dclp_dp
  import dclp_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       current_duty,
  input  dclp_cmd_t        cmd,
  output dclp_stat_t       stat,
  output resp_code_t       response_code,
  output logic             set_strobe,
  output logic [7:0]       result_value
);

  localparam int IDX_W = $clog2(LINE_CAPACITY);

  localparam logic [2:0] KW_LEN     = 3'd7;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;
  localparam logic [9:0] NUM_SAT    = 10'd999;
  localparam logic [9:0] DUTY_MAX   = 10'd100;

  // Number field parser: waiting for the first digit, in the digits,
  // in trailing blanks after the digits, or a non-digit (or a digit after the blanks) was seen.
  typedef enum logic [3:0] {
    NUM_WAIT   = 4'b0001,
    NUM_DIGITS = 4'b0010,
    NUM_TRAIL  = 4'b0100,
    NUM_BAD    = 4'b1000
  } num_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= CHAR_LA) && (c <= CHAR_LZ)) ? (c - CASE_DIFF) : c;
  endfunction

  // Keyword characters: "SET PWM" or "GET PWM", differing only in the first.
  function automatic logic [7:0] kw_char(input logic is_get, input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = is_get ? "G" : "S";
      3'd1:    ch = "E";
      3'd2:    ch = "T";
      3'd3:    ch = " ";
      3'd4:    ch = "P";
      3'd5:    ch = "W";
      3'd6:    ch = "M";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  logic [7:0]       mem [LINE_CAPACITY];
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             discard_r, discard_nxt;
  logic             tl_r, tl_nxt;
  logic             proc_vld_r;
  logic [IDX_W-1:0] len_r;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [7:0]       rd_data_r;
  logic [7:0]       duty_r;

  logic             nonempty_r, nonempty_nxt;
  logic [2:0]       kidx_r, kidx_nxt;
  logic             set_m_r, set_m_nxt;
  logic             get_m_r, get_m_nxt;
  num_state_t       num_st_r, num_st_nxt;
  logic [9:0]       val_r, val_nxt;

  resp_code_t       code_r;
  logic             strobe_r;
  logic [7:0]       value_r;

  logic [7:0]       uc;
  logic             ws;
  logic             digit;
  logic [13:0]      v_ext;
  logic [9:0]       v_sat;

  resp_code_t       res_code;
  logic             res_strobe;
  logic [7:0]       res_value;
  logic             res_has;

  assign stat.is_term    = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.cnt_full   = (cnt_r == IDX_W'(LINE_CAPACITY - 1));
  assign stat.discard    = discard_r;
  assign stat.scan_last  = (ptr_r == (len_r - IDX_W'(1)));
  assign stat.has_result = res_has;

  assign response_code = code_r;
  assign set_strobe    = strobe_r;
  assign result_value  = value_r;

  // Line store: written as bytes arrive, read once per cycle during the scan.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[cnt_r] <= rx_byte;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    discard_nxt = discard_r;
    tl_nxt      = tl_r;
    ptr_nxt     = ptr_r;
    if (cmd.start_scan || cmd.too_long) begin
      cnt_nxt = '0;
    end else if (cmd.store) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end
    if (cmd.set_discard) begin
      discard_nxt = 1'b1;
    end else if (cmd.clr_discard) begin
      discard_nxt = 1'b0;
    end
    if (cmd.too_long) begin
      tl_nxt = 1'b1;
    end else if (cmd.start_scan) begin
      tl_nxt = 1'b0;
    end
    if (cmd.start_scan) begin
      ptr_nxt = '0;
    end else if (cmd.scan_rd) begin
      ptr_nxt = ptr_r + IDX_W'(1);
    end
  end

  // One parser step per stored byte.
  assign uc    = to_upper(rd_data_r);
  assign ws    = is_ws(rd_data_r);
  assign digit = (rd_data_r >= CHAR_ZERO) && (rd_data_r <= CHAR_NINE);
  assign v_ext = ({4'b0, val_r} << 3) + ({4'b0, val_r} << 1) + {10'b0, rd_data_r[3:0]};
  assign v_sat = (v_ext > 14'(NUM_SAT)) ? NUM_SAT : v_ext[9:0];

  always_comb begin
    nonempty_nxt = nonempty_r;
    kidx_nxt     = kidx_r;
    set_m_nxt    = set_m_r;
    get_m_nxt    = get_m_r;
    num_st_nxt   = num_st_r;
    val_nxt      = val_r;
    if (cmd.start_scan) begin
      nonempty_nxt = 1'b0;
      kidx_nxt     = 3'd0;
      set_m_nxt    = 1'b0;
      get_m_nxt    = 1'b0;
      num_st_nxt   = NUM_WAIT;
      val_nxt      = '0;
    end else if (proc_vld_r) begin
      if (!nonempty_r) begin
        // Leading blanks are skipped; the first other byte opens the keyword.
        if (!ws) begin
          nonempty_nxt = 1'b1;
          kidx_nxt     = 3'd1;
          set_m_nxt    = (uc == kw_char(1'b0, 3'd0));
          get_m_nxt    = (uc == kw_char(1'b1, 3'd0));
        end
      end else if (kidx_r != KW_LEN) begin
        set_m_nxt = set_m_r && (uc == kw_char(1'b0, kidx_r));
        get_m_nxt = get_m_r && (uc == kw_char(1'b1, kidx_r));
        kidx_nxt  = kidx_r + 3'd1;
      end else begin
        // A GET takes nothing after the keyword but trailing blanks.
        if (!ws) begin
          get_m_nxt = 1'b0;
        end
        if (set_m_r) begin
          unique case (num_st_r)
            NUM_WAIT: begin
              if (digit) begin
                val_nxt    = {6'b0, rd_data_r[3:0]};
                num_st_nxt = NUM_DIGITS;
              end else if (!ws) begin
                num_st_nxt = NUM_BAD;
              end
            end
            NUM_DIGITS: begin
              if (digit) begin
                val_nxt = v_sat;
              end else if (ws) begin
                num_st_nxt = NUM_TRAIL;
              end else begin
                num_st_nxt = NUM_BAD;
              end
            end
            NUM_TRAIL: begin
              if (!ws) begin
                num_st_nxt = NUM_BAD;
              end
            end
            NUM_BAD: begin
              num_st_nxt = NUM_BAD;
            end
            default: begin
              num_st_nxt = NUM_BAD;
            end
          endcase
        end
      end
    end
  end

  // Result of the finished line.
  always_comb begin
    res_code   = RESP_UNKNOWN;
    res_strobe = 1'b0;
    res_value  = 8'h00;
    res_has    = 1'b1;
    if (tl_r) begin
      res_code = RESP_TOO_LONG;
    end else if (!nonempty_r) begin
      res_has = 1'b0;
    end else if ((kidx_r == KW_LEN) && set_m_r) begin
      if (num_st_r == NUM_WAIT) begin
        res_code = RESP_MISSING;
      end else if (num_st_r == NUM_BAD) begin
        res_code = RESP_BAD_NUM;
      end else if (val_r > DUTY_MAX) begin
        res_code = RESP_RANGE;
      end else begin
        res_code   = RESP_SET_OK;
        res_strobe = 1'b1;
        res_value  = val_r[7:0];
      end
    end else if ((kidx_r == KW_LEN) && get_m_r) begin
      res_code  = RESP_REPORT;
      res_value = duty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      discard_r  <= 1'b0;
      tl_r       <= 1'b0;
      proc_vld_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      discard_r  <= discard_nxt;
      tl_r       <= tl_nxt;
      proc_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    nonempty_r <= nonempty_nxt;
    kidx_r     <= kidx_nxt;
    set_m_r    <= set_m_nxt;
    get_m_r    <= get_m_nxt;
    num_st_r   <= num_st_nxt;
    val_r      <= val_nxt;
    if (cmd.start_scan) begin
      len_r  <= cnt_r;
      duty_r <= current_duty;
    end
    if (cmd.load_out) begin
      code_r   <= res_code;
      strobe_r <= res_strobe;
      value_r  <= res_value;
    end
  end

endmodule

>>> rtl/duty_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// duty_command_line_parser_core: serial command line parser for a duty value
// Collects bytes into a line, and at CR or LF parses GET PWM / SET PWM <n>.
// ----------------------------------------------------------------------------
// A byte that is stored or dropped, or an empty terminator, leaves the controller idle.
// A terminator ending a line of n stored bytes holds in_tready low through the scan
// (one line store read per byte), the drain state and the finish state, which waits
// while the output register is full; a too-long line goes straight to the finish state.
// Reset (rst_n low, synchronous) clears the byte count, the discard flag and
// the output valid; the line store is not cleared, only written bytes are read.
module duty_command_line_parser_core
  import dclp_pkg::*;
#(
  parameter int LINE_CAPACITY = 64
)
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel, one received byte per transaction.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [15:8] current_duty
  // Result channel, at most one transaction per line.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] response_code, [3] set_strobe,
                                  // [11:4] result_value, [15:12] zero
);

  dclp_cmd_t  cmd;
  dclp_stat_t stat;
  resp_code_t response_code;
  logic       set_strobe;
  logic [7:0] result_value;

  // The controller owns both handshakes. Input is taken whenever it is idle,
  // also while an earlier result still waits in the output register; a new
  // result waits in the finish state until that register is free.
  dclp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath stores the line, walks it one byte per cycle through the
  // trim, keyword and number parser, and holds the registered result.
  dclp_dp #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_byte       (in_tdata[7:0]),
    .current_duty  (in_tdata[15:8]),
    .cmd           (cmd),
    .stat          (stat),
    .response_code (response_code),
    .set_strobe    (set_strobe),
    .result_value  (result_value)
  );

  assign out_tdata = {4'b0000, result_value, set_strobe, response_code};

endmodule

>>> rtl/dclp_checker.sv
// ----------------------------------------------------------------------------
// dclp_checker: port-level checks for the duty command line parser
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module dclp_checker
  import dclp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The strobe goes with set ok alone, and an applied duty never exceeds 100.
  a_strobe_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3] == (out_tdata[2:0] == RESP_SET_OK)) &&
                   ((out_tdata[2:0] != RESP_SET_OK) || (out_tdata[11:4] <= 8'd100)))
    else $error("set strobe or applied duty inconsistent");

  // Error responses carry a zero value and a code within the defined set.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != RESP_SET_OK) && (out_tdata[2:0] != RESP_REPORT)
      |-> (out_tdata[11:4] == 8'h00) && (out_tdata[2:0] != 3'd7) &&
          (out_tdata[15:12] == 4'h0))
    else $error("error response carries a value or bad code");

endmodule

bind duty_command_line_parser_core dclp_checker u_dclp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
